// ===== src/priority_ordered_list_unit_assert.svh =====
// Assertion macros shared by the priority ordered list RTL.
`ifndef PRIORITY_ORDERED_LIST_UNIT_ASSERT_SVH
`define PRIORITY_ORDERED_LIST_UNIT_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define POL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("priority list check failed");

// Antecedent implies consequent in the same cycle.
`define POL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("priority list check failed");

// Antecedent implies consequent in the following cycle.
`define POL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("priority list check failed");

`endif

// ===== src/pol_pkg.sv =====
// Shared types and constants of the priority ordered list.
package pol_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int DEFAULT_TAG_BITS = 8;
   localparam int ITEM_TAG_BITS    = 8;
   localparam int PRIO_BITS        = 5;
   localparam int COUNT_OUT_BITS   = 7;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_POP    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_REM_RD,
      ST_REM_CMP,
      ST_REM_END,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [ITEM_TAG_BITS-1:0] item_tag;
      logic [3:0]               grade;
      logic [3:0]               difficulty;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                status;
      logic                      head_valid;
      logic [ITEM_TAG_BITS-1:0]  head_tag;
      logic [PRIO_BITS-1:0]      head_priority;
      logic [COUNT_OUT_BITS-1:0] entry_count;
   } rsp_word_type;

endpackage

// ===== src/pol_ram.sv =====
// Entry store: one write port, one registered read port.
module pol_ram #(
   parameter int DEPTH = pol_pkg::DEFAULT_CAPACITY,
   parameter int WIDTH = pol_pkg::DEFAULT_TAG_BITS + pol_pkg::PRIO_BITS
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (write_enable) begin
         store_ff[write_addr] <= write_data;
      end
   end

   // read one entry, data next cycle
   always_ff @(posedge clock) begin
      read_data_ff <= store_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// ===== src/priority_ordered_list_unit.sv =====
// Priority ordered list: top level with the scan sequencer and result register.
//
// Holds up to CAPACITY tagged entries ordered by descending priority
// (grade + difficulty), head at slot 0 of an entry memory with one write
// and one registered read port. Each word on req_ is insert, remove by tag
// or pop head; each yields one rsp_ word with status, head entry and count.
// One word is in work at a time and req_stall stays high until it is
// finished; a finished result waits in the output register while the next
// word is taken. Every scan step reads one memory entry and compares or
// moves it: an insert scans from the tail toward the insertion point, a
// remove scans every held entry from the head and a pop from slot one;
// a full insert, an empty remove or pop or an unused command goes
// straight to the result. A finished result waits while the one in the
// output register is stalled. The memory needs no clearing after reset.
`include "priority_ordered_list_unit_assert.svh"

module priority_ordered_list_unit #(
   parameter int CAPACITY = pol_pkg::DEFAULT_CAPACITY,
   parameter int TAG_BITS = pol_pkg::DEFAULT_TAG_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pol_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pol_pkg::rsp_word_type rsp_word
);

   localparam int AW        = $clog2(CAPACITY);
   localparam int CW        = $clog2(CAPACITY + 1);
   localparam int PB        = pol_pkg::PRIO_BITS;
   localparam int EW        = TAG_BITS + PB;
   localparam int OUT_TAG   = pol_pkg::ITEM_TAG_BITS;
   localparam int OUT_COUNT = pol_pkg::COUNT_OUT_BITS;

   pol_pkg::state_type    state_ff, state_in;
   pol_pkg::status_type   status_ff, status_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  found_ff, found_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [PB-1:0]         prio_ff, prio_in;
   logic [TAG_BITS-1:0]   head_tag_ff, head_tag_in;
   logic [PB-1:0]         head_prio_ff, head_prio_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pol_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [EW-1:0]         mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [EW-1:0]         mem_rdata;

   logic [CW-1:0]         k_dec;
   logic [TAG_BITS-1:0]   rd_tag;
   logic [PB-1:0]         rd_prio;
   logic                  rd_lower;
   logic                  list_full;
   logic                  list_empty;
   logic                  out_free;
   logic                  load_rsp;
   logic [PB-1:0]         new_prio;

   pol_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (EW)
   ) u_ram (
      .clock        (clock),
      .write_enable (mem_we),
      .write_addr   (mem_waddr),
      .write_data   (mem_wdata),
      .read_addr    (mem_raddr),
      .read_data    (mem_rdata)
   );

   // decode shared terms
   assign k_dec      = k_ff - 1'b1;
   assign rd_tag     = mem_rdata[EW-1:PB];
   assign rd_prio    = mem_rdata[PB-1:0];
   assign rd_lower   = rd_prio < prio_ff;
   assign list_full  = count_ff == CW'(CAPACITY);
   assign list_empty = count_ff == '0;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign new_prio   = PB'(req_word.grade) + PB'(req_word.difficulty);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pol_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (pol_pkg::cmd_type'(req_word.cmd))
                  pol_pkg::CMD_INSERT: begin
                     if (list_full) begin
                        state_in = pol_pkg::ST_FINISH;
                     end else if (list_empty) begin
                        state_in = pol_pkg::ST_INS_PUT;
                     end else begin
                        state_in = pol_pkg::ST_INS_RD;
                     end
                  end
                  pol_pkg::CMD_REMOVE,
                  pol_pkg::CMD_POP: begin
                     state_in = list_empty ? pol_pkg::ST_FINISH : pol_pkg::ST_REM_RD;
                  end
                  default: begin
                     state_in = pol_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         pol_pkg::ST_INS_RD: begin
            state_in = pol_pkg::ST_INS_CMP;
         end
         pol_pkg::ST_INS_CMP: begin
            state_in = (rd_lower && k_dec != '0) ? pol_pkg::ST_INS_RD : pol_pkg::ST_INS_PUT;
         end
         pol_pkg::ST_INS_PUT: begin
            state_in = pol_pkg::ST_FINISH;
         end
         pol_pkg::ST_REM_RD: begin
            state_in = (k_ff == count_ff) ? pol_pkg::ST_REM_END : pol_pkg::ST_REM_CMP;
         end
         pol_pkg::ST_REM_CMP: begin
            state_in = pol_pkg::ST_REM_RD;
         end
         pol_pkg::ST_REM_END: begin
            state_in = pol_pkg::ST_FINISH;
         end
         pol_pkg::ST_FINISH: begin
            state_in = out_free ? pol_pkg::ST_IDLE : pol_pkg::ST_FINISH;
         end
         default: begin
            state_in = pol_pkg::ST_IDLE;
         end
      endcase
   end

   // memory controls and handshake outputs
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = k_ff[AW-1:0];
      mem_wdata = {tag_ff, prio_ff};
      mem_raddr = k_ff[AW-1:0];
      load_rsp  = 1'b0;
      req_stall = state_ff != pol_pkg::ST_IDLE;
      unique case (state_ff)
         pol_pkg::ST_INS_RD: begin
            mem_raddr = k_dec[AW-1:0];
         end
         pol_pkg::ST_INS_CMP: begin
            // move a lower entry one slot toward the tail
            if (rd_lower) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata;
            end
         end
         pol_pkg::ST_INS_PUT: begin
            mem_we = 1'b1;
         end
         pol_pkg::ST_REM_CMP: begin
            // close the gap behind the removed entry
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = k_dec[AW-1:0];
               mem_wdata = mem_rdata;
            end
         end
         pol_pkg::ST_FINISH: begin
            load_rsp = out_free;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      k_in         = k_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      tag_in       = tag_ff;
      prio_in      = prio_ff;
      status_in    = status_ff;
      head_tag_in  = head_tag_ff;
      head_prio_in = head_prio_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      unique case (state_ff)
         pol_pkg::ST_IDLE: begin
            if (req_valid) begin
               tag_in    = TAG_BITS'(req_word.item_tag);
               prio_in   = new_prio;
               status_in = pol_pkg::STATUS_DONE;
               found_in  = 1'b0;
               k_in      = '0;
               unique case (pol_pkg::cmd_type'(req_word.cmd))
                  pol_pkg::CMD_INSERT: begin
                     k_in = count_ff;
                     if (list_full) begin
                        status_in = pol_pkg::STATUS_FULL;
                     end
                  end
                  pol_pkg::CMD_REMOVE: begin
                     if (list_empty) begin
                        status_in = pol_pkg::STATUS_MISSING;
                     end
                  end
                  pol_pkg::CMD_POP: begin
                     // head is dropped: start shifting from slot one
                     found_in = 1'b1;
                     k_in     = CW'(1);
                     if (list_empty) begin
                        status_in = pol_pkg::STATUS_MISSING;
                     end
                  end
                  default: begin
                     status_in = pol_pkg::STATUS_DONE;
                  end
               endcase
            end
         end
         pol_pkg::ST_INS_CMP: begin
            if (rd_lower) begin
               k_in = k_dec;
            end
         end
         pol_pkg::ST_INS_PUT: begin
            count_in = count_ff + 1'b1;
         end
         pol_pkg::ST_REM_CMP: begin
            if (!found_ff && rd_tag == tag_ff) begin
               found_in = 1'b1;
            end
            k_in = k_ff + 1'b1;
         end
         pol_pkg::ST_REM_END: begin
            if (found_ff) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = pol_pkg::STATUS_MISSING;
            end
         end
         default: begin
            k_in = k_ff;
         end
      endcase

      // track the head copy whenever slot zero is written
      if (mem_we && mem_waddr == '0) begin
         head_tag_in  = mem_wdata[EW-1:PB];
         head_prio_in = mem_wdata[PB-1:0];
      end

      // load or drain the result register
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.status        = status_ff;
         rsp_word_in.head_valid    = !list_empty;
         rsp_word_in.head_tag      = list_empty ? '0 : OUT_TAG'(head_tag_ff);
         rsp_word_in.head_priority = list_empty ? '0 : head_prio_ff;
         rsp_word_in.entry_count   = OUT_COUNT'(count_ff);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pol_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      found_ff     <= found_in;
      tag_ff       <= tag_in;
      prio_ff      <= prio_in;
      status_ff    <= status_in;
      head_tag_ff  <= head_tag_in;
      head_prio_ff <= head_prio_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `POL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY))
   `POL_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != pol_pkg::ST_IDLE)
   `POL_ASSERT_IMPLY(a_write_in_list, clock, reset, mem_we, k_ff <= count_ff)

endmodule

// ===== tb/priority_ordered_list_unit_tb.sv =====
// Self-checking testbench for the priority ordered list unit.
module priority_ordered_list_unit_tb;
   import pol_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int TAG_BITS     = DEFAULT_TAG_BITS;
   localparam int RANDOM_ITEMS = 2000;
   // longest correct quiet stretch is a full scan plus a sender gap and a stall run
   localparam int STUCK_LIMIT  = 4000;
   localparam int SCAN_CYCLES  = 2 * CAPACITY + 8;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_mode_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // Keeps a copy of the ordered list and the result words it predicts.
   class ordered_list_checker;
      logic [TAG_BITS-1:0]  held_tag[$];
      logic [PRIO_BITS-1:0] held_prio[$];
      rsp_word_type         expected_rsp[$];
      int mismatches;
      int checked;
      int peak_fill;
      int cmd_seen[4];
      int status_seen[3];

      // Apply one accepted request word to the list and queue its result.
      function void note_request(req_word_type w);
         rsp_word_type         r;
         logic [TAG_BITS-1:0]  t;
         logic [PRIO_BITS-1:0] p;
         int                   pos;
         int                   hit;
         t = w.item_tag[TAG_BITS-1:0];
         p = w.grade + w.difficulty;
         r = '0;
         r.status = STATUS_DONE;
         case (w.cmd)
            CMD_INSERT: begin
               if (held_tag.size() >= CAPACITY) begin
                  r.status = STATUS_FULL;
               end else begin
                  // go past every entry of equal or higher priority
                  pos = 0;
                  while (pos < held_tag.size() && held_prio[pos] >= p) pos++;
                  held_tag.insert(pos, t);
                  held_prio.insert(pos, p);
               end
            end
            CMD_REMOVE: begin
               hit = -1;
               for (pos = 0; pos < held_tag.size() && hit < 0; pos++) begin
                  if (held_tag[pos] == t) hit = pos;
               end
               if (hit < 0) begin
                  r.status = STATUS_MISSING;
               end else begin
                  held_tag.delete(hit);
                  held_prio.delete(hit);
               end
            end
            CMD_POP: begin
               if (held_tag.size() == 0) begin
                  r.status = STATUS_MISSING;
               end else begin
                  held_tag.delete(0);
                  held_prio.delete(0);
               end
            end
            default: ;
         endcase
         if (held_tag.size() > 0) begin
            r.head_valid    = 1'b1;
            r.head_tag      = ITEM_TAG_BITS'(held_tag[0]);
            r.head_priority = held_prio[0];
         end
         r.entry_count = COUNT_OUT_BITS'(held_tag.size());
         if (held_tag.size() > peak_fill) peak_fill = held_tag.size();
         cmd_seen[w.cmd]++;
         status_seen[r.status]++;
         expected_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
         if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatches++;
         end
      endfunction

      // Match one accepted result word against the oldest prediction.
      function void check_response(rsp_word_type got);
         rsp_word_type exp_rsp;
         if (expected_rsp.size() == 0) begin
            $error("result word %h arrived with no request pending", got);
            mismatches++;
            return;
         end
         exp_rsp = expected_rsp.pop_front();
         checked++;
         compare_field("status", exp_rsp.status, got.status);
         compare_field("head_valid", exp_rsp.head_valid, got.head_valid);
         compare_field("head_tag", exp_rsp.head_tag, got.head_tag);
         compare_field("head_priority", exp_rsp.head_priority, got.head_priority);
         compare_field("entry_count", exp_rsp.entry_count, got.entry_count);
      endfunction
   endclass

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   ordered_list_checker list_board = new;
   int burst_left   = 0;
   int stuck_cycles = 0;
   int random_sent  = 0;

   priority_ordered_list_unit #(
      .CAPACITY(CAPACITY),
      .TAG_BITS(TAG_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the result side in runs of changing character.
   stall_mode_type stall_mode = STALL_NONE;
   int stall_left = 0;
   int stall_tick = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(3));
         stall_left <= $urandom_range(10, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(3) != 0);
         default:     rsp_stall <= ((stall_tick % 5) < 3);
      endcase
      stall_tick <= stall_tick + 1;
   end

   // Check result words and track how long nothing has moved.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) list_board.check_response(rsp_word);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("priority_ordered_list_unit: mismatch");
      $finish;
   end

   function automatic req_word_type make_word(logic [1:0] cmd, logic [7:0] tag,
                                              logic [3:0] grade, logic [3:0] diff);
      req_word_type w;
      w.cmd        = cmd;
      w.item_tag   = tag;
      w.grade      = grade;
      w.difficulty = diff;
      return w;
   endfunction

   // Offer one request word, opening a new burst with a random gap when due.
   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      list_board.note_request(w);
   endtask

   // Hold off the sender until every predicted result has been checked.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (list_board.expected_rsp.size() != 0);
      burst_left = 0;
   endtask

   // Pick a command by phase mix; removes mostly target a held tag.
   function automatic req_word_type random_word(mix_mode_type mode, bit narrow_tags);
      int          insert_pct;
      logic [1:0]  cmd;
      logic [7:0]  tag;
      int          held;
      insert_pct = (mode == MIX_FILL) ? 85 : (mode == MIX_DRAIN) ? 12 : 50;
      tag  = narrow_tags ? 8'($urandom_range(7)) : 8'($urandom_range(255));
      held = list_board.held_tag.size();
      if ($urandom_range(99) < 3) begin
         cmd = CMD_UNUSED;
      end else if ($urandom_range(99) < insert_pct) begin
         cmd = CMD_INSERT;
      end else if ($urandom_range(1) == 0) begin
         cmd = CMD_REMOVE;
         if (held > 0 && $urandom_range(4) != 0)
            tag = 8'(list_board.held_tag[$urandom_range(held - 1)]);
      end else begin
         cmd = CMD_POP;
      end
      return make_word(cmd, tag, 4'($urandom_range(15)), 4'($urandom_range(15)));
   endfunction

   initial begin
      mix_mode_type mode;
      int           phase_len;
      bit           narrow_tags;
      req_word_type w;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty list: pop, remove and unused code all leave it alone
      send_word(make_word(CMD_POP,    8'h00, 4'h0, 4'h0));
      send_word(make_word(CMD_REMOVE, 8'h00, 4'h0, 4'h0));
      send_word(make_word(CMD_UNUSED, 8'hFF, 4'hF, 4'hF));
      // extremes of priority and tag, equal priorities keep arrival order
      send_word(make_word(CMD_INSERT, 8'h00, 4'h0, 4'h0));
      send_word(make_word(CMD_INSERT, 8'hFF, 4'hF, 4'hF));
      send_word(make_word(CMD_INSERT, 8'h5A, 4'hF, 4'h0));
      send_word(make_word(CMD_INSERT, 8'hA5, 4'h0, 4'hF));
      send_word(make_word(CMD_INSERT, 8'h5A, 4'h7, 4'h8));
      // duplicate tag: only the one nearest the head goes
      send_word(make_word(CMD_REMOVE, 8'h5A, 4'h0, 4'h0));
      send_word(make_word(CMD_REMOVE, 8'h33, 4'hF, 4'hF));
      send_word(make_word(CMD_UNUSED, 8'h00, 4'h0, 4'h0));
      send_word(make_word(CMD_POP,    8'hFF, 4'hF, 4'hF));
      send_word(make_word(CMD_INSERT, 8'h01, 4'hF, 4'hF));
      send_word(make_word(CMD_INSERT, 8'hFE, 4'hA, 4'h5));
      send_word(make_word(CMD_REMOVE, 8'h00, 4'h0, 4'h0));
      send_word(make_word(CMD_REMOVE, 8'hFE, 4'h0, 4'h0));
      repeat (5) send_word(make_word(CMD_POP, 8'h00, 4'h0, 4'h0));
      wait_drained();

      // random phases that fill, drain or churn the list
      while (random_sent < RANDOM_ITEMS) begin
         mode        = mix_mode_type'($urandom_range(2));
         phase_len   = $urandom_range(20, 120);
         narrow_tags = ($urandom_range(2) == 0);
         repeat (phase_len) begin
            w = random_word(mode, narrow_tags);
            send_word(w);
            if (w.cmd != CMD_UNUSED) random_sent++;
         end
         if ($urandom_range(3) == 0) wait_drained();
      end
      wait_drained();
      repeat (SCAN_CYCLES) @(posedge clock);

      $display("covered %0d inserts (%0d refused as full), %0d removes, %0d pops, %0d unused codes",
               list_board.cmd_seen[CMD_INSERT], list_board.status_seen[STATUS_FULL],
               list_board.cmd_seen[CMD_REMOVE], list_board.cmd_seen[CMD_POP],
               list_board.cmd_seen[CMD_UNUSED]);
      $display("%0d results checked, %0d not found or empty, peak fill %0d of %0d",
               list_board.checked, list_board.status_seen[STATUS_MISSING],
               list_board.peak_fill, CAPACITY);
      if (list_board.mismatches == 0 && list_board.expected_rsp.size() == 0) begin
         $display("priority_ordered_list_unit: match");
      end else begin
         $display("priority_ordered_list_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/pol_pkg.sv
src/pol_ram.sv
src/priority_ordered_list_unit.sv
tb/priority_ordered_list_unit_tb.sv
